>>> sv/bba_pkg.sv
// Shared definitions of the buddy block allocator: default sizes, port widths,
// result codes, datapath micro-operation codes and the controller/datapath structs.
// No dependencies.
package bba_pkg;

	// Default geometry
	localparam int PAGES_DEF        = 16;
	localparam int LEVEL_COUNT_DEF  = 8;
	localparam int MIN_SHIFT_DEF    = 5;
	localparam int HEADER_BYTES_DEF = 24;

	// Fixed field widths
	localparam int REQ_W       = 12;
	localparam int ADDR_W      = 16;
	localparam int LIMIT_W     = 5;
	localparam int STATUS_W    = 2;
	localparam int LEVEL_OUT_W = 3;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd3;

	typedef logic [4:0] op_t;

	// Datapath micro-operations
	localparam op_t OP_NOP    = 5'd0;
	localparam op_t OP_CLEAR  = 5'd1;
	localparam op_t OP_LOAD   = 5'd2;
	localparam op_t OP_FIND   = 5'd3;
	localparam op_t OP_MAP    = 5'd4;
	localparam op_t OP_PUSHA  = 5'd5;
	localparam op_t OP_PUSHB  = 5'd6;
	localparam op_t OP_POPA   = 5'd7;
	localparam op_t OP_POPB   = 5'd8;
	localparam op_t OP_DECL   = 5'd9;
	localparam op_t OP_HI     = 5'd10;
	localparam op_t OP_TAKE   = 5'd11;
	localparam op_t OP_RDH    = 5'd12;
	localparam op_t OP_CHKH   = 5'd13;
	localparam op_t OP_RDB    = 5'd14;
	localparam op_t OP_UNLRD  = 5'd15;
	localparam op_t OP_SETLVL = 5'd16;
	localparam op_t OP_UNLW   = 5'd17;
	localparam op_t OP_TOPF   = 5'd18;
	localparam op_t OP_OUT    = 5'd19;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic pre_bad;
		logic is_free;
		logic found;
		logic page_ok;
		logic head_nil;
		logic split_need;
		logic hdr_taken;
		logic l_top;
		logic bud_match;
		logic out_free;
	} dp_stat_t;

endpackage

>>> sv/buddy_block_allocator.sv
// Top level of the buddy block allocator: configuration register, controller
// and datapath. Depends on bba_pkg, bba_ctrl, bba_datapath.
//
//   channel | signals                                          | flow control
//   in      | in_valid, operation, request_bytes, free_address | in_stall
//   out     | out_valid, user_address, result_status, block_level | out_stall
//   cfg     | cfg_valid, pages_in_use_limit                    | cfg_ready
//
// After reset a clearing pass writes every block header; no item is taken during
// it. An allocate takes a block from a ready list, or maps a page first, and splits
// larger blocks as needed; a free merges the block with free buddies, and an
// ignored item only reports its status. One item is in work at a time; the next
// is taken while its result waits in the output register.
module buddy_block_allocator import bba_pkg::*; #(
	parameter int PAGES        = PAGES_DEF,
	parameter int LEVEL_COUNT  = LEVEL_COUNT_DEF,
	parameter int MIN_SHIFT    = MIN_SHIFT_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   operation,
	input  logic [REQ_W-1:0]       request_bytes,
	input  logic [ADDR_W-1:0]      free_address,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [ADDR_W-1:0]      user_address,
	output logic [STATUS_W-1:0]    result_status,
	output logic [LEVEL_OUT_W-1:0] block_level,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [LIMIT_W-1:0]     pages_in_use_limit
);

	cmd_t               cmd;
	dp_stat_t           stat;
	logic [LIMIT_W-1:0] limit_q;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= pages_in_use_limit;
		end
	end

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	bba_datapath #(
		.PAGES        (PAGES),
		.LEVEL_COUNT  (LEVEL_COUNT),
		.MIN_SHIFT    (MIN_SHIFT),
		.HEADER_BYTES (HEADER_BYTES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.operation     (operation),
		.request_bytes (request_bytes),
		.free_address  (free_address),
		.limit         (limit_q),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.user_address  (user_address),
		.result_status (result_status),
		.block_level   (block_level)
	);

endmodule

>>> sv/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/bba_datapath.sv
// Datapath of the buddy allocator: block header and free-list link memories,
// list heads, page map, result and output registers.
// Depends on bba_pkg and bba_ram.
module bba_datapath import bba_pkg::*; #(
	parameter int PAGES        = PAGES_DEF,
	parameter int LEVEL_COUNT  = LEVEL_COUNT_DEF,
	parameter int MIN_SHIFT    = MIN_SHIFT_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output dp_stat_t               stat,
	input  logic                   operation,
	input  logic [REQ_W-1:0]       request_bytes,
	input  logic [ADDR_W-1:0]      free_address,
	input  logic [LIMIT_W-1:0]     limit,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic [ADDR_W-1:0]      user_address,
	output logic [STATUS_W-1:0]    result_status,
	output logic [LEVEL_OUT_W-1:0] block_level
);

	localparam int TOP      = LEVEL_COUNT - 1;
	localparam int GRANULES = PAGES << TOP;
	localparam int GW       = $clog2(GRANULES);
	localparam int LW       = $clog2(GRANULES + 1);
	localparam int LVL_W    = $clog2(LEVEL_COUNT);
	localparam int HW       = LVL_W + 1;
	localparam int PW       = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int CNT_W    = $clog2(PAGES + 1);
	localparam int CMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	localparam logic [LW-1:0]          NIL     = LW'(GRANULES);
	localparam logic [LVL_W-1:0]       TOP_L   = LVL_W'(TOP);
	localparam logic [LEVEL_OUT_W-1:0] TOP_OUT = LEVEL_OUT_W'(TOP % 8);
	localparam logic [ADDR_W-1:0]      OFF_MSK = ADDR_W'((1 << MIN_SHIFT) - 1);

	// Control registers
	logic [LW-1:0]    head_q [LEVEL_COUNT];
	logic [PAGES-1:0] page_map_q;
	logic [CNT_W-1:0] cnt_q;
	logic [GW-1:0]    clr_q;
	logic             out_valid_q;

	// Working registers
	logic                   is_free_q;
	logic [LVL_W-1:0]       want_q;
	logic [GW-1:0]          b_q;
	logic [GW-1:0]          bud_q;
	logic [LVL_W-1:0]       l_q;
	logic [LW-1:0]          h_q;
	logic [STATUS_W-1:0]    res_status_q;
	logic [LEVEL_OUT_W-1:0] res_level_q;
	logic [ADDR_W-1:0]      res_addr_q;
	logic [ADDR_W-1:0]      out_addr_q;
	logic [STATUS_W-1:0]    out_status_q;
	logic [LEVEL_OUT_W-1:0] out_level_q;

	// Memory ports
	logic          hdr_we, nxt_we, prv_we;
	logic [GW-1:0] hdr_wa, nxt_wa, prv_wa, hdr_ra, nxt_ra, prv_ra;
	logic [HW-1:0] hdr_wd, hdr_rd;
	logic [LW-1:0] nxt_wd, prv_wd, nxt_rd, prv_rd;

	// Decode of the incoming item
	logic [REQ_W:0]       total;
	logic [LVL_W-1:0]     want_c;
	logic                 over_c;
	logic [ADDR_W-1:0]    off;
	logic [31:0]          g32;
	logic                 bad_free;
	logic [STATUS_W-1:0]  pre_status;

	// Searches and helpers
	logic [LVL_W-1:0] j_c;
	logic             found_c;
	logic [PW-1:0]    pg_c;
	logic             pg_any;
	logic             page_ok;
	logic [LW-1:0]    head_cur;
	logic [GW-1:0]    mask_l;
	logic             hdr_taken;
	logic [LVL_W-1:0] hdr_lvl;
	logic [31:0]      pg_b32;
	logic [31:0]      l32;
	logic [31:0]      ua32;

	assign total = {1'b0, request_bytes} + (REQ_W + 1)'(HEADER_BYTES);

	// Smallest level that holds the request plus header
	always_comb begin
		want_c = TOP_L;
		over_c = 1'b1;
		for (int i = TOP; i >= 0; i--) begin
			if (32'(total) <= (32'd1 << (MIN_SHIFT + i))) begin
				want_c = LVL_W'(i);
				over_c = 1'b0;
			end
		end
	end

	// Free address checks
	assign off      = free_address - ADDR_W'(HEADER_BYTES);
	assign g32      = 32'(off) >> MIN_SHIFT;
	assign bad_free = (free_address < ADDR_W'(HEADER_BYTES)) || ((off & OFF_MSK) != '0) ||
	                  (g32 >= 32'(GRANULES));

	always_comb begin
		if (operation) begin
			pre_status = bad_free ? ST_IGNORED : ST_OK;
		end else if (request_bytes == '0) begin
			pre_status = ST_IGNORED;
		end else begin
			pre_status = over_c ? ST_TOO_LARGE : ST_OK;
		end
	end

	// Nearest nonempty list at or above the wanted level
	always_comb begin
		j_c     = '0;
		found_c = 1'b0;
		for (int i = TOP; i >= 0; i--) begin
			if (LVL_W'(i) >= want_q && head_q[i] != NIL) begin
				j_c     = LVL_W'(i);
				found_c = 1'b1;
			end
		end
	end

	// Lowest unmapped page
	always_comb begin
		pg_c   = '0;
		pg_any = 1'b0;
		for (int i = PAGES - 1; i >= 0; i--) begin
			if (!page_map_q[i]) begin
				pg_c   = PW'(i);
				pg_any = 1'b1;
			end
		end
	end

	assign page_ok   = pg_any && (CMP_W'(cnt_q) < CMP_W'(limit));
	assign head_cur  = head_q[l_q];
	assign mask_l    = GW'(1) << l_q;
	assign hdr_taken = hdr_rd[HW-1];
	assign hdr_lvl   = hdr_rd[LVL_W-1:0];
	assign pg_b32    = 32'(b_q) >> TOP;
	assign l32       = 32'(l_q);
	assign ua32      = (32'(b_q) << MIN_SHIFT) + 32'(HEADER_BYTES);

	// Status to the controller
	always_comb begin
		stat.clr_last   = (clr_q == GW'(GRANULES - 1));
		stat.pre_bad    = (res_status_q != ST_OK);
		stat.is_free    = is_free_q;
		stat.found      = found_c;
		stat.page_ok    = page_ok;
		stat.head_nil   = (head_cur == NIL);
		stat.split_need = (l_q > want_q);
		stat.hdr_taken  = hdr_taken;
		stat.l_top      = (l_q >= TOP_L);
		stat.bud_match  = !hdr_taken && (hdr_lvl == l_q);
		stat.out_free   = !out_valid_q || !out_stall;
	end

	// Memory port selection
	always_comb begin
		hdr_we = 1'b0;
		hdr_wa = b_q;
		hdr_wd = {1'b0, l_q};
		hdr_ra = b_q;
		nxt_we = 1'b0;
		nxt_wa = b_q;
		nxt_wd = head_cur;
		nxt_ra = head_cur[GW-1:0];
		prv_we = 1'b0;
		prv_wa = b_q;
		prv_wd = NIL;
		prv_ra = bud_q;
		unique case (cmd.op)
			OP_CLEAR: begin
				hdr_we = 1'b1;
				hdr_wa = clr_q;
				hdr_wd = '0;
			end
			OP_PUSHA: begin
				hdr_we = 1'b1;
				nxt_we = 1'b1;
				prv_we = 1'b1;
			end
			OP_PUSHB: begin
				prv_we = 1'b1;
				prv_wa = h_q[GW-1:0];
				prv_wd = LW'(b_q);
			end
			OP_POPB: begin
				prv_we = (nxt_rd != NIL);
				prv_wa = nxt_rd[GW-1:0];
			end
			OP_TAKE: begin
				hdr_we = 1'b1;
				hdr_wd = {1'b1, l_q};
			end
			OP_RDB: begin
				hdr_ra = b_q ^ mask_l;
			end
			OP_UNLRD: begin
				nxt_ra = bud_q;
			end
			OP_UNLW: begin
				// unlink buddy, write header of the merged block
				nxt_we = (prv_rd != NIL);
				nxt_wa = prv_rd[GW-1:0];
				nxt_wd = nxt_rd;
				prv_we = (nxt_rd != NIL);
				prv_wa = nxt_rd[GW-1:0];
				prv_wd = prv_rd;
				hdr_we = 1'b1;
				hdr_wa = b_q & ~mask_l;
				hdr_wd = {1'b0, LVL_W'(l_q + 1'b1)};
			end
			OP_TOPF: begin
				hdr_we = 1'b1;
				hdr_wd = {1'b0, TOP_L};
			end
			default: begin
			end
		endcase
	end

	bba_ram #(.WIDTH(HW), .DEPTH(GRANULES)) u_hdr_ram (
		.clk(clk), .we(hdr_we), .waddr(hdr_wa), .wdata(hdr_wd), .raddr(hdr_ra), .rdata(hdr_rd)
	);

	bba_ram #(.WIDTH(LW), .DEPTH(GRANULES)) u_next_ram (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(nxt_ra), .rdata(nxt_rd)
	);

	bba_ram #(.WIDTH(LW), .DEPTH(GRANULES)) u_prev_ram (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(prv_ra), .rdata(prv_rd)
	);

	// List heads, page map, clear sweep, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVEL_COUNT; i++) begin
				head_q[i] <= NIL;
			end
			page_map_q  <= '0;
			cnt_q       <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_CLEAR: clr_q <= clr_q + 1'b1;
				OP_MAP: begin
					page_map_q[pg_c] <= 1'b1;
					cnt_q            <= cnt_q + 1'b1;
				end
				OP_PUSHA: head_q[l_q] <= LW'(b_q);
				OP_POPB:  head_q[l_q] <= nxt_rd;
				OP_UNLW: begin
					if (prv_rd == NIL) begin
						head_q[l_q] <= nxt_rd;
					end
				end
				OP_TOPF: begin
					if (page_map_q[pg_b32[PW-1:0]]) begin
						page_map_q[pg_b32[PW-1:0]] <= 1'b0;
						cnt_q                      <= cnt_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working and result registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				is_free_q    <= operation;
				want_q       <= want_c;
				b_q          <= g32[GW-1:0];
				res_status_q <= pre_status;
				res_level_q  <= '0;
				res_addr_q   <= '0;
			end
			OP_FIND: begin
				if (found_c) begin
					l_q <= j_c;
				end else if (!page_ok) begin
					res_status_q <= ST_EXHAUSTED;
				end
			end
			OP_MAP: begin
				b_q <= GW'(32'(pg_c) << TOP);
				l_q <= TOP_L;
			end
			OP_PUSHA: h_q <= head_cur;
			OP_POPA:  b_q <= head_cur[GW-1:0];
			OP_DECL:  l_q <= l_q - 1'b1;
			OP_HI:    b_q <= b_q | mask_l;
			OP_TAKE: begin
				res_addr_q  <= ua32[ADDR_W-1:0];
				res_level_q <= l32[LEVEL_OUT_W-1:0];
			end
			OP_CHKH: begin
				l_q <= hdr_lvl;
				if (!hdr_taken) begin
					res_status_q <= ST_IGNORED;
				end
			end
			OP_RDB:    bud_q <= b_q ^ mask_l;
			OP_SETLVL: res_level_q <= l32[LEVEL_OUT_W-1:0];
			OP_UNLW: begin
				b_q <= b_q & ~mask_l;
				l_q <= l_q + 1'b1;
			end
			OP_TOPF: res_level_q <= TOP_OUT;
			OP_OUT: begin
				out_addr_q   <= res_addr_q;
				out_status_q <= res_status_q;
				out_level_q  <= res_level_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign user_address  = out_addr_q;
	assign result_status = out_status_q;
	assign block_level   = out_level_q;

`ifndef SYNTHESIS
	// mapped page count tracks the page map
	a_cnt_matches: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) == $countones(page_map_q))
		else $error("mapped page count out of step with page map");

	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT) |-> (!out_valid_q || !out_stall))
		else $error("result overwritten while stalled");

	// a new mapping stays under the limit
	a_map_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_MAP) |-> (CMP_W'(cnt_q) < CMP_W'(limit)))
		else $error("page mapped past the limit");
`endif

endmodule

>>> sv/bba_ctrl.sv
// Controller state machine of the buddy allocator: sequences the datapath
// micro-operations for the clear sweep, allocate and free.
// Depends on bba_pkg.
module bba_ctrl import bba_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output cmd_t     cmd
);

	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_DEC   = 5'd2;
	localparam logic [4:0] S_FIND  = 5'd3;
	localparam logic [4:0] S_MAP   = 5'd4;
	localparam logic [4:0] S_PA    = 5'd5;
	localparam logic [4:0] S_PB    = 5'd6;
	localparam logic [4:0] S_CHK   = 5'd7;
	localparam logic [4:0] S_POPA  = 5'd8;
	localparam logic [4:0] S_POPB  = 5'd9;
	localparam logic [4:0] S_DECL  = 5'd10;
	localparam logic [4:0] S_HI    = 5'd11;
	localparam logic [4:0] S_TAKE  = 5'd12;
	localparam logic [4:0] S_RDH   = 5'd13;
	localparam logic [4:0] S_CHKH  = 5'd14;
	localparam logic [4:0] S_LOOP  = 5'd15;
	localparam logic [4:0] S_RDB   = 5'd16;
	localparam logic [4:0] S_CHKB  = 5'd17;
	localparam logic [4:0] S_UNL   = 5'd18;
	localparam logic [4:0] S_TOPF  = 5'd19;
	localparam logic [4:0] S_DONE  = 5'd20;

	// where a push returns to
	localparam logic [1:0] RET_CHK  = 2'd0;
	localparam logic [1:0] RET_HI   = 2'd1;
	localparam logic [1:0] RET_DONE = 2'd2;

	logic [4:0] state_q, state_d, ret_state;
	logic [1:0] ret_q, ret_d;
	logic       fin_q, fin_d;

	always_comb begin
		unique case (ret_q)
			RET_CHK:  ret_state = S_CHK;
			RET_HI:   ret_state = S_HI;
			default:  ret_state = S_DONE;
		endcase
	end

	// Next state and command
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		fin_d   = fin_q;
		cmd.op  = OP_NOP;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				priority if (stat.pre_bad) begin
					state_d = S_DONE;
				end else if (stat.is_free) begin
					state_d = S_RDH;
				end else begin
					state_d = S_FIND;
				end
			end
			S_FIND: begin
				cmd.op = OP_FIND;
				priority if (stat.found) begin
					state_d = S_CHK;
				end else if (stat.page_ok) begin
					state_d = S_MAP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_MAP: begin
				cmd.op  = OP_MAP;
				ret_d   = RET_CHK;
				state_d = S_PA;
			end
			S_PA: begin
				cmd.op  = OP_PUSHA;
				state_d = stat.head_nil ? ret_state : S_PB;
			end
			S_PB: begin
				cmd.op  = OP_PUSHB;
				state_d = ret_state;
			end
			S_CHK: begin
				fin_d   = !stat.split_need;
				state_d = S_POPA;
			end
			S_POPA: begin
				cmd.op  = OP_POPA;
				state_d = S_POPB;
			end
			S_POPB: begin
				cmd.op  = OP_POPB;
				state_d = fin_q ? S_TAKE : S_DECL;
			end
			S_DECL: begin
				cmd.op  = OP_DECL;
				ret_d   = RET_HI;
				state_d = S_PA;
			end
			S_HI: begin
				cmd.op  = OP_HI;
				ret_d   = RET_CHK;
				state_d = S_PA;
			end
			S_TAKE: begin
				cmd.op  = OP_TAKE;
				state_d = S_DONE;
			end
			S_RDH: begin
				cmd.op  = OP_RDH;
				state_d = S_CHKH;
			end
			S_CHKH: begin
				cmd.op  = OP_CHKH;
				state_d = stat.hdr_taken ? S_LOOP : S_DONE;
			end
			S_LOOP: begin
				state_d = stat.l_top ? S_TOPF : S_RDB;
			end
			S_RDB: begin
				cmd.op  = OP_RDB;
				state_d = S_CHKB;
			end
			S_CHKB: begin
				if (stat.bud_match) begin
					cmd.op  = OP_UNLRD;
					state_d = S_UNL;
				end else begin
					cmd.op  = OP_SETLVL;
					ret_d   = RET_DONE;
					state_d = S_PA;
				end
			end
			S_UNL: begin
				cmd.op  = OP_UNLW;
				state_d = S_LOOP;
			end
			S_TOPF: begin
				cmd.op  = OP_TOPF;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ret_q   <= RET_DONE;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			fin_q   <= fin_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule
